// ===== src/tws_pkg.sv =====
// shared types and constants of the exact-filter weighting block
`timescale 1ns / 1ps
package tws_pkg;

  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 34;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 40;

  localparam logic [30:0] Q30_ONE      = 31'd1073741824;
  localparam logic [17:0] DEG_TO_Q30   = 18'd146409;
  localparam logic [23:0] PI_Q22       = 24'd13176825;
  localparam logic [31:0] PI_Q30       = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic [55:0] EPS_Q30      = 56'd1074;
  localparam logic [55:0] WIDTH_Q30    = 56'd3373267315;
  localparam logic [15:0] FULL_TURN    = 16'd46080;
  localparam logic [15:0] QUARTER_TURN = 16'd11520;

  localparam logic [2:0] CFG_SIZE_X     = 3'd0;
  localparam logic [2:0] CFG_SIZE_Y     = 3'd1;
  localparam logic [2:0] CFG_SIZE_Z     = 3'd2;
  localparam logic [2:0] CFG_THICKNESS  = 3'd3;
  localparam logic [2:0] CFG_TILT_COUNT = 3'd4;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } tilt_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
    logic [6:0]         nbits;
  } div_req_t;

  // reciprocals of the taylor divisors 110, 72, 42, 20, 6, innermost first
  // exact floor for any 32-bit dividend with the shifts in kern_quot
  function automatic logic [32:0] kern_recip(input logic [2:0] idx);
    logic [32:0] m;
    case (idx)
      3'd0:    m = 33'd4997780127;
      3'd1:    m = 33'd7635497416;
      3'd2:    m = 33'd6544712071;
      3'd3:    m = 33'd6871947674;
      default: m = 33'd5726623062;
    endcase
    return m;
  endfunction

  // quotient from the reciprocal product, shift 39, 39, 38, 37, 35
  function automatic logic [30:0] kern_quot(input logic [MUL_P_W-1:0] p,
                                            input logic [2:0] idx);
    logic [30:0] q;
    case (idx)
      3'd0:    q = 31'(p[64:39]);
      3'd1:    q = 31'(p[64:39]);
      3'd2:    q = 31'(p[64:38]);
      3'd3:    q = 31'(p[64:37]);
      default: q = 31'(p[64:35]);
    endcase
    return q;
  endfunction

endpackage

// ===== src/tomo_weight_3d_sinc_sum.sv =====
// top level: exact-filter weighting sequencer for 3d weighted backprojection
// usage
//   a request is taken when start is high and busy is low. kind selects the job:
//   load stores one tilt (azimuth, elevation) in slot tilt_slot as a tilt vector
//   scaled by pi times the sample thickness; evaluate sums one sinc term for each
//   of the first tilt_count tilts for voxel (index_x, index_y, index_z) and returns the weight.
//   a load gives no result. an evaluate gives one weight, unsigned q1.15, on
//   weight for exactly one cycle with result_valid high; the receiver cannot
//   stall, so nothing is held back.
//   configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data, always
//   ready, and is meant to be written only while busy is low.
// timing
//   one registered multiplier and one restoring divider (one quotient bit a
//   cycle) are shared; the kernel divides by its constants through reciprocal products.
//   load: four sines, then the scaled vector.
//   evaluate: the divider work sets the busy time (three 53-bit axis divides and
//   a 61-bit sinc divide per tilt in range, a 46-bit final one when the sum exceeds one).
//   a new request is taken in the cycle that the result is shown.
// reset: synchronous, restores register defaults; the tilt store is not cleared
`timescale 1ns / 1ps
module tomo_weight_3d_sinc_sum import tws_pkg::*; #(
  parameter int MAX_TILTS  = 64,
  parameter int MAX_EXTENT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [5:0]         tilt_slot,
  input  logic signed [15:0] azimuth_deg,
  input  logic signed [15:0] elevation_deg,
  input  logic [9:0]         index_x,
  input  logic [9:0]         index_y,
  input  logic [9:0]         index_z,
  output logic [15:0]        weight,
  output logic               result_valid,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int ADDR_W = (MAX_TILTS > 1) ? $clog2(MAX_TILTS) : 1;
  localparam int CNT_W  = $clog2(MAX_TILTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, L_ANG, L_ANGX, L_ANGR, L_ZW1, L_ZW2, L_ZW3, L_Z2, L_Z3, L_X, L_Y,
    E_RD, E_LATCH, E_AX_MUL, E_AX_DIV, E_AX_WAIT, E_ARG, E_SDIV, E_SWAIT,
    E_NEXT, E_FIN, E_FWAIT,
    K_SQ, K_SQR, K_MT, K_MTR, K_DW, K_FIN, K_FR
  } state_t;

  // configuration registers
  logic [10:0] size_x, size_y, size_z;
  logic [9:0]  thick;
  logic [6:0]  tilt_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x     <= 11'd64;
      size_y     <= 11'd64;
      size_z     <= 11'd64;
      thick      <= 10'd1;
      tilt_count <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SIZE_X:     size_x     <= cfg_data;
        CFG_SIZE_Y:     size_y     <= cfg_data;
        CFG_SIZE_Z:     size_z     <= cfg_data;
        CFG_THICKNESS:  thick      <= cfg_data[9:0];
        CFG_TILT_COUNT: tilt_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_t state, ret;
  logic [1:0]  j;
  logic [2:0]  ki;
  logic [1:0]  ax;
  logic [CNT_W-1:0] i, count;
  logic [30:0] kx, t, s;
  logic [31:0] x2;
  logic [30:0] sp, cp, st, ct, zw;
  logic [MUL_B_W-1:0] tp;
  logic        n_sp, n_cp, n_st, n_ct, aneg, sneg;
  logic [31:0] vx, vz;
  logic signed [15:0] phi, theta;
  logic [ADDR_W-1:0] slot;
  logic [10:0] m_mag [3];
  logic        m_neg [3];
  logic [10:0] n_ax  [3];
  logic [9:0]  h_ax  [3];
  logic [31:0] v_mag [3];
  logic        v_neg [3];
  logic signed [56:0] arg;
  logic [31:0] amag;
  logic signed [39:0] sum;

  // shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  div_req_t           dreq;
  logic               div_done;
  logic [DIV_N_W-1:0] quot;

  tws_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  tws_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .quot(quot));

  // tilt store
  logic        mem_we;
  tilt_t       mem_wdata, mem_rdata;
  logic [31:0] vy_now;

  tws_tilt_mem #(.DEPTH(MAX_TILTS), .ADDR_W(ADDR_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(slot), .wdata(mem_wdata),
    .raddr(i[ADDR_W-1:0]), .rdata(mem_rdata)
  );

  assign busy = (state != S_IDLE);

  // angle reduction for the degree sine
  logic signed [16:0] ang;
  logic [15:0] r, f, g;
  logic [1:0]  quad;

  always_comb begin
    ang = 17'(j[1] ? theta : phi) + (j[0] ? 17'sd11520 : 17'sd0);
    r   = (ang < 0) ? 16'(ang + 17'sd46080) : 16'(ang);
    if (r < QUARTER_TURN) begin
      quad = 2'd0;
      f    = r;
    end else if (r < 16'(2 * 11520)) begin
      quad = 2'd1;
      f    = r - QUARTER_TURN;
    end else if (r < 16'(3 * 11520)) begin
      quad = 2'd2;
      f    = r - 16'(2 * 11520);
    end else begin
      quad = 2'd3;
      f    = r - 16'(3 * 11520);
    end
    g = quad[0] ? QUARTER_TURN - f : f;
  end

  // rounding of the tilt vector products
  logic [64:0] rnd33;
  logic [63:0] rnd30;

  assign rnd33 = {1'b0, prod[63:0]} + 65'(64'd1 << 32);
  assign rnd30 = prod[63:0] + (64'd1 << 29);
  assign vy_now = rnd30[61:30];

  always_comb begin
    mem_we    = (state == L_Y);
    mem_wdata.x = (n_st != n_cp) ? -vx : vx;
    mem_wdata.y = (n_st != n_sp) ? -vy_now : vy_now;
    mem_wdata.z = n_ct ? -vz : vz;
  end

  // argument magnitude and kernel input for the sinc term
  logic [56:0] arg_abs;
  logic [32:0] pi_diff;

  assign arg_abs = arg[56] ? 57'(-arg) : 57'(arg);
  assign pi_diff = {1'b0, PI_Q30} - {1'b0, arg_abs[31:0]};

  // evaluate set-up from the request
  logic [9:0]  k_in [3];
  logic [10:0] sz_in [3];
  logic [12:0] n_sat [3];
  logic [10:0] n_in [3];
  logic [9:0]  h_in [3];
  logic signed [11:0] m_in [3];
  logic [8:0]  count_in;

  always_comb begin
    k_in[0]  = index_x;
    k_in[1]  = index_y;
    k_in[2]  = index_z;
    sz_in[0] = size_x;
    sz_in[1] = size_y;
    sz_in[2] = size_z;
    for (int a = 0; a < 3; a++) begin
      n_sat[a] = (13'(sz_in[a]) > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : 13'(sz_in[a]);
      n_in[a]  = (n_sat[a] == 13'd0) ? 11'd1 : n_sat[a][10:0];
      h_in[a]  = n_in[a][10:1];
      m_in[a]  = (k_in[a] < h_in[a]) ? 12'(k_in[a])
               : 12'(k_in[a]) - 12'({h_in[a], 1'b0});
    end
    count_in = (9'(tilt_count) > 9'(MAX_TILTS)) ? 9'(MAX_TILTS) : 9'(tilt_count);
  end

  // operand selection for the shared units
  logic [40:0] sin_num;
  logic [46:0] fin_num;

  assign sin_num = {1'b0, s, 9'd0};
  assign fin_num = 47'(46'd1 << 45) + 47'(sum[39:1]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      L_ANG:    begin mul_a = MUL_A_W'(g);          mul_b = MUL_B_W'(DEG_TO_Q30); end
      K_SQ:     begin mul_a = MUL_A_W'(kx);         mul_b = MUL_B_W'(kx); end
      K_MT:     begin mul_a = MUL_A_W'(x2);         mul_b = MUL_B_W'(t); end
      K_MTR:    begin mul_a = MUL_A_W'(prod[61:30]); mul_b = MUL_B_W'(kern_recip(ki)); end
      K_FIN:    begin mul_a = MUL_A_W'(kx);         mul_b = MUL_B_W'(t); end
      L_ZW1:    begin mul_a = MUL_A_W'(thick);      mul_b = MUL_B_W'(PI_Q22); end
      L_ZW2:    begin mul_a = MUL_A_W'(st);         mul_b = prod[MUL_B_W-1:0]; end
      L_Z2:     begin mul_a = MUL_A_W'(ct);         mul_b = tp; end
      L_Z3:     begin mul_a = MUL_A_W'(zw);         mul_b = MUL_B_W'(cp); end
      L_X:      begin mul_a = MUL_A_W'(zw);         mul_b = MUL_B_W'(sp); end
      E_AX_MUL: begin mul_a = MUL_A_W'(m_mag[ax]);  mul_b = MUL_B_W'(v_mag[ax]); end
      default: ;
    endcase
  end

  always_comb begin
    dreq = '0;
    unique case (state)
      E_AX_DIV: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_N_W'({prod[41:0], 11'd0}) + DIV_N_W'(h_ax[ax]);
        dreq.den   = DIV_D_W'(n_ax[ax]);
        dreq.nbits = 7'd53;
      end
      E_SDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {sin_num, 23'd0} >> 2;
        dreq.den   = DIV_D_W'(amag);
        dreq.nbits = 7'd61;
      end
      E_FIN: begin
        dreq.start = (sum > 40'sd1073741824);
        dreq.num   = DIV_N_W'(fin_num);
        dreq.den   = DIV_D_W'(sum[38:0]);
        dreq.nbits = 7'd46;
      end
      default: ;
    endcase
  end

  // sequencer
  logic [61:0] sq_x2;
  logic [30:0] kern_out;

  assign sq_x2    = prod[61:0];
  assign kern_out = (prod[63:30] > 34'(Q30_ONE)) ? Q30_ONE : prod[60:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      result_valid <= 1'b0;
      j            <= '0;
      ki           <= '0;
      ax           <= '0;
      i            <= '0;
      count        <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_LOAD) begin
              phi   <= azimuth_deg;
              theta <= elevation_deg;
              slot  <= ADDR_W'(tilt_slot);
              j     <= 2'd0;
              if (9'(tilt_slot) < 9'(MAX_TILTS)) begin
                state <= L_ANG;
              end
            end else begin
              for (int a = 0; a < 3; a++) begin
                n_ax[a]  <= n_in[a];
                h_ax[a]  <= h_in[a];
                m_neg[a] <= m_in[a][11];
                m_mag[a] <= m_in[a][11] ? 11'(-m_in[a]) : m_in[a][10:0];
              end
              count <= CNT_W'(count_in);
              i     <= '0;
              sum   <= '0;
              state <= (count_in == 9'd0) ? E_FIN : E_RD;
            end
          end
        end
        // load: four sines, then the scaled vector
        L_ANG: begin
          aneg  <= quad[1];
          state <= L_ANGX;
        end
        L_ANGX: begin
          kx    <= prod[30:0];
          ret   <= L_ANGR;
          state <= K_SQ;
        end
        L_ANGR: begin
          unique case (j)
            2'd0: begin sp <= s; n_sp <= aneg; end
            2'd1: begin cp <= s; n_cp <= aneg; end
            2'd2: begin st <= s; n_st <= aneg; end
            default: begin ct <= s; n_ct <= aneg; end
          endcase
          j     <= j + 2'd1;
          state <= (j == 2'd3) ? L_ZW1 : L_ANG;
        end
        // pi times thickness first, kept for both products
        L_ZW1: state <= L_ZW2;
        L_ZW2: begin
          tp    <= prod[MUL_B_W-1:0];
          state <= L_ZW3;
        end
        L_ZW3: begin
          zw    <= rnd33[63:33];
          state <= L_Z2;
        end
        L_Z2: state <= L_Z3;
        L_Z3: begin
          vz    <= rnd33[64:33];
          state <= L_X;
        end
        L_X: begin
          vx    <= rnd30[61:30];
          state <= L_Y;
        end
        L_Y: state <= S_IDLE;
        // evaluate: one tilt after another
        E_RD: state <= E_LATCH;
        E_LATCH: begin
          v_neg[0] <= mem_rdata.x[31];
          v_neg[1] <= mem_rdata.y[31];
          v_neg[2] <= mem_rdata.z[31];
          v_mag[0] <= mem_rdata.x[31] ? 32'(-mem_rdata.x) : mem_rdata.x;
          v_mag[1] <= mem_rdata.y[31] ? 32'(-mem_rdata.y) : mem_rdata.y;
          v_mag[2] <= mem_rdata.z[31] ? 32'(-mem_rdata.z) : mem_rdata.z;
          arg      <= '0;
          ax       <= 2'd0;
          state    <= E_AX_MUL;
        end
        E_AX_MUL: state <= E_AX_DIV;
        E_AX_DIV: state <= E_AX_WAIT;
        E_AX_WAIT: begin
          if (div_done) begin
            arg   <= (m_neg[ax] != v_neg[ax]) ? arg - 57'(quot[53:0]) : arg + 57'(quot[53:0]);
            ax    <= ax + 2'd1;
            state <= (ax == 2'd2) ? E_ARG : E_AX_MUL;
          end
        end
        E_ARG: begin
          amag <= arg_abs[31:0];
          if (56'(arg_abs) < EPS_Q30) begin
            sum   <= sum + 40'sd1073741824;
            state <= E_NEXT;
          end else if (56'(arg_abs) < WIDTH_Q30) begin
            if (arg_abs[31:0] > HALF_PI_Q30) begin
              sneg <= pi_diff[32];
              kx   <= pi_diff[32] ? 31'(-pi_diff) : pi_diff[30:0];
            end else begin
              sneg <= 1'b0;
              kx   <= arg_abs[30:0];
            end
            ret   <= E_SDIV;
            state <= K_SQ;
          end else begin
            state <= E_NEXT;
          end
        end
        E_SDIV: state <= E_SWAIT;
        E_SWAIT: begin
          if (div_done) begin
            sum   <= sneg ? sum - 40'(quot[31:0]) : sum + 40'(quot[31:0]);
            state <= E_NEXT;
          end
        end
        E_NEXT: begin
          if (i + CNT_W'(1) == count) begin
            state <= E_FIN;
          end else begin
            i     <= i + CNT_W'(1);
            state <= E_RD;
          end
        end
        E_FIN: begin
          if (sum > 40'sd1073741824) begin
            state <= E_FWAIT;
          end else begin
            weight       <= 16'd32768;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        E_FWAIT: begin
          if (div_done) begin
            weight       <= quot[15:0];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        // sine kernel subroutine on kx, result in s
        K_SQ: state <= K_SQR;
        K_SQR: begin
          x2    <= sq_x2[61:30];
          t     <= Q30_ONE;
          ki    <= 3'd0;
          state <= K_MT;
        end
        K_MT:  state <= K_MTR;
        K_MTR: state <= K_DW;
        // constant divide taken from the reciprocal product
        K_DW: begin
          t     <= Q30_ONE - kern_quot(prod, ki);
          ki    <= ki + 3'd1;
          state <= (ki == 3'd4) ? K_FIN : K_MT;
        end
        K_FIN: state <= K_FR;
        K_FR: begin
          s     <= kern_out;
          state <= ret;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result without a request in flight");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (weight <= 16'd32768))
    else $error("weight above one");
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_EVAL) |=> busy)
    else $error("evaluate request not taken");
  a_div_only_waiting: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == E_AX_WAIT || state == E_SWAIT || state == E_FWAIT))
    else $error("divider finished outside a wait step");
`endif

endmodule

// ===== src/tws_mul.sv =====
// shared registered multiplier
`timescale 1ns / 1ps
module tws_mul import tws_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== src/tws_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tws_div import tws_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  div_req_t           req,
  output logic               done,
  output logic [DIV_N_W-1:0] quot
);

  logic               running;
  logic [6:0]         cnt;
  logic [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den;
  logic [DIV_D_W:0]   remsh;
  logic [DIV_D_W:0]   diff;
  logic               ge;

  assign remsh = {rem, dvd[DIV_N_W-1]};
  assign ge    = remsh >= {1'b0, den};
  assign diff  = remsh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= req.nbits;
        dvd     <= req.num << (7'd64 - req.nbits);
        rem     <= '0;
        den     <= req.den;
        quot    <= '0;
      end else if (running) begin
        rem  <= ge ? diff[DIV_D_W-1:0] : remsh[DIV_D_W-1:0];
        dvd  <= {dvd[DIV_N_W-2:0], 1'b0};
        quot <= {quot[DIV_N_W-2:0], ge};
        cnt  <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/tws_tilt_mem.sv =====
// tilt vector store, one write and one registered read port
`timescale 1ns / 1ps
module tws_tilt_mem import tws_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  tilt_t             wdata,
  input  logic [ADDR_W-1:0] raddr,
  output tilt_t             rdata
);

  tilt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tomo_weight_3d_sinc_sum_tb.sv =====
// self-checking testbench of the exact-filter weighting block
`timescale 1ns / 1ps
module tomo_weight_3d_sinc_sum_tb;
  import tws_pkg::*;

  // fixed-point constants of the weighting arithmetic
  localparam longint unsigned ONE_Q30   = 64'd1073741824;
  localparam longint unsigned DEG_Q30   = 64'd146409;
  localparam longint unsigned PI_Q22_L  = 64'd13176825;
  localparam longint          PI_Q30_L  = 64'sd3373259426;
  localparam longint unsigned HALF_PI_L = 64'd1686629713;
  localparam longint unsigned EPS_L     = 64'd1074;
  localparam longint unsigned WIDTH_L   = 64'd3373267315;
  localparam int              TURN      = 46080;
  localparam int              QUARTER   = 11520;
  localparam int              NSLOTS    = 64;
  localparam int              EXTENT_MAX = 1024;
  localparam logic [2:0]      CFG_SPARE_LO = 3'd5;   // first index with no register

  typedef struct {
    logic               kind;
    logic [5:0]         slot;
    logic signed [15:0] az;
    logic signed [15:0] el;
    logic [9:0]         ix;
    logic [9:0]         iy;
    logic [9:0]         iz;
  } voxel_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               kind = KIND_LOAD;
  logic [5:0]         tilt_slot = '0;
  logic signed [15:0] azimuth_deg = '0;
  logic signed [15:0] elevation_deg = '0;
  logic [9:0]         index_x = '0;
  logic [9:0]         index_y = '0;
  logic [9:0]         index_z = '0;
  logic [15:0]        weight;
  logic               result_valid;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [10:0]        cfg_data = '0;

  tomo_weight_3d_sinc_sum dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .tilt_slot(tilt_slot), .azimuth_deg(azimuth_deg), .elevation_deg(elevation_deg),
    .index_x(index_x), .index_y(index_y), .index_z(index_z),
    .weight(weight), .result_valid(result_valid),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the block: registers and tilt store
  int unsigned ext_x = 64, ext_y = 64, ext_z = 64, thick = 1, ntilts = 0;
  int          vec_x [NSLOTS];
  int          vec_y [NSLOTS];
  int          vec_z [NSLOTS];
  bit [NSLOTS-1:0] slot_loaded = '0;

  voxel_req_t  pending_reqs [$];
  logic [15:0] weights_due [$];
  int          mismatches = 0;
  int          stray_results = 0;
  bit          no_gaps = 1'b0;
  int          gap_left = 0;

  // truncated taylor sine on a q30 angle, saturated at one
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2, t;
    int unsigned     dv [5];
    dv = '{110, 72, 42, 20, 6};
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 5; i++) t = ONE_Q30 - ((x2 * t) >> 30) / dv[i];
    t = (x * t) >> 30;
    return (t > ONE_Q30) ? ONE_Q30 : t;
  endfunction

  // sine of a q8.7 degree angle, magnitude plus sign
  function automatic longint unsigned sine_of_deg(int a, output bit neg);
    int r, q, f, g;
    r = ((a % TURN) + TURN) % TURN;
    q = r / QUARTER;
    f = r % QUARTER;
    g = (q & 1) ? QUARTER - f : f;
    neg = (q >= 2);
    return sine_q30(longint'(g) * DEG_Q30);
  endfunction

  // sine of a q30 radian magnitude up to about pi
  function automatic longint unsigned sine_of_rad(longint unsigned a, output bit neg);
    longint d;
    neg = 1'b0;
    if (a > HALF_PI_L) begin
      d = PI_Q30_L - longint'(a);
      if (d < 0) begin
        neg = 1'b1;
        return sine_q30(longint'(-d));
      end
      return sine_q30(longint'(d));
    end
    return sine_q30(a);
  endfunction

  // one axis contribution to the sinc argument, q30
  function automatic longint freq_dot(int unsigned k, int unsigned nreg, int v);
    longint unsigned n, h, mag, q;
    longint          m, p;
    n = (nreg == 0) ? 1 : ((nreg > EXTENT_MAX) ? EXTENT_MAX : nreg);
    h = n / 2;
    m = (k < h) ? longint'(k) : longint'(k) - 2 * longint'(h);
    p = m * longint'(v) * 2048;
    mag = (p < 0) ? longint'(-p) : longint'(p);
    q = (mag + n / 2) / n;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int apply_sign(longint unsigned mag, bit neg);
    return neg ? -int'(mag) : int'(mag);
  endfunction

  task automatic store_tilt(input voxel_req_t r);
    bit n_sp, n_cp, n_st, n_ct;
    longint unsigned sp, cp, st, ct, zw, vx, vy, vz;
    sp = sine_of_deg(int'(r.az), n_sp);
    cp = sine_of_deg(int'(r.az) + QUARTER, n_cp);
    st = sine_of_deg(int'(r.el), n_st);
    ct = sine_of_deg(int'(r.el) + QUARTER, n_ct);
    zw = (st * thick * PI_Q22_L + (64'd1 << 32)) >> 33;
    vx = (zw * cp + (64'd1 << 29)) >> 30;
    vy = (zw * sp + (64'd1 << 29)) >> 30;
    vz = (ct * thick * PI_Q22_L + (64'd1 << 32)) >> 33;
    vec_x[r.slot] = apply_sign(vx, n_st != n_cp);
    vec_y[r.slot] = apply_sign(vy, n_st != n_sp);
    vec_z[r.slot] = apply_sign(vz, n_ct);
  endtask

  function automatic logic [15:0] voxel_weight(input voxel_req_t r);
    int unsigned     cnt;
    longint          sum, arg;
    longint unsigned a, s, q, d;
    bit              neg;
    cnt = (ntilts > NSLOTS) ? NSLOTS : ntilts;
    sum = 0;
    for (int i = 0; i < cnt; i++) begin
      arg = freq_dot(r.ix, ext_x, vec_x[i]) + freq_dot(r.iy, ext_y, vec_y[i])
          + freq_dot(r.iz, ext_z, vec_z[i]);
      a = (arg < 0) ? longint'(-arg) : longint'(arg);
      if (a < EPS_L) begin
        sum += longint'(ONE_Q30);
      end else if (a < WIDTH_L) begin
        s = sine_of_rad(a, neg);
        q = (s << 30) / a;
        sum += neg ? -longint'(q) : longint'(q);
      end
    end
    if (sum > longint'(ONE_Q30)) begin
      d = sum;
      return 16'(((64'd1 << 45) + d / 2) / d);
    end
    return 16'd32768;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // request driver: holds a request until taken, then waits out a random gap
  always @(posedge clk) begin
    voxel_req_t r;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        r.kind = kind; r.slot = tilt_slot; r.az = azimuth_deg; r.el = elevation_deg;
        r.ix = index_x; r.iy = index_y; r.iz = index_z;
        if (r.kind == KIND_LOAD) store_tilt(r);
        else weights_due.push_back(voxel_weight(r));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          r = pending_reqs.pop_front();
          start <= 1'b1;
          kind <= r.kind; tilt_slot <= r.slot;
          azimuth_deg <= r.az; elevation_deg <= r.el;
          index_x <= r.ix; index_y <= r.iy; index_z <= r.iz;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe must match the oldest weight due
  always @(posedge clk) begin
    logic [15:0] exp_w;
    if (!rst && result_valid) begin
      if (weights_due.size() == 0) begin
        stray_results++;
        if (mismatches + stray_results <= 10)
          $display("unexpected result: weight=%0d", weight);
      end else begin
        exp_w = weights_due.pop_front();
        if (weight !== exp_w) begin
          mismatches++;
          if (mismatches + stray_results <= 10)
            $display("weight mismatch: expected %0d, got %0d", exp_w, weight);
        end
      end
    end
  end

  task automatic push_load(input int slot, input int az, input int el);
    voxel_req_t r;
    r = '{KIND_LOAD, 6'(slot), 16'(az), 16'(el), 10'($urandom), 10'($urandom),
          10'($urandom)};
    slot_loaded[slot] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic push_eval(input int ix, input int iy, input int iz);
    voxel_req_t r;
    r = '{KIND_EVAL, 6'($urandom), 16'($urandom), 16'($urandom), 10'(ix), 10'(iy),
          10'(iz)};
    pending_reqs.push_back(r);
  endtask

  // let every request finish, including a trailing load with no result
  task automatic drain();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || busy || weights_due.size() != 0);
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 11'(val);
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE_X:     ext_x = val & 11'h7ff;
      CFG_SIZE_Y:     ext_y = val & 11'h7ff;
      CFG_SIZE_Z:     ext_z = val & 11'h7ff;
      CFG_THICKNESS:  thick = val & 10'h3ff;
      CFG_TILT_COUNT: ntilts = val & 7'h7f;
      default: ;
    endcase
  endtask

  function automatic int pick_angle();
    case ($urandom_range(0, 9))
      0: return -23040;
      1: return 23040;
      2: return 0;
      3: return ($urandom_range(0, 1) ? 11520 : -11520);
      default: return int'($urandom_range(0, 46080)) - 23040;
    endcase
  endfunction

  function automatic int unsigned pick_extent();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 1024;
      4: return 2047;
      5: return 1023;
      6, 7: return $urandom_range(3, 1024);
      default: return $urandom_range(3, 96);
    endcase
  endfunction

  // number of slots loaded from slot zero upwards
  function automatic int loaded_prefix();
    int n;
    n = 0;
    while (n < NSLOTS && slot_loaded[n]) n++;
    return n;
  endfunction

  initial begin
    int unsigned cnt, th;
    int          lim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: no tilts summed gives full weight, then tilt extremes
    push_eval(0, 0, 0);
    push_eval(1023, 1023, 1023);
    push_load(0, 0, 0);
    push_load(1, 23040, 23040);
    push_load(2, -23040, -23040);
    push_load(3, 11520, 11520);
    push_load(4, -11520, 5760);
    push_load(5, 32767 - 9727, -23040);
    push_load(6, pick_angle(), pick_angle());
    push_load(7, 0, 11520);
    drain();
    write_reg(CFG_TILT_COUNT, 8);
    // zero index gives zero argument: each term counts one
    push_eval(0, 0, 0);
    push_eval(1023, 1023, 1023);
    push_eval(31, 32, 33);
    push_eval(63, 0, 1);
    push_eval(1, 1, 1);
    push_eval(500, 17, 999);
    drain();
    // zero and oversized extents, thickness extremes, a spare index
    write_reg(CFG_SIZE_X, 0);
    write_reg(CFG_SIZE_Y, 2047);
    write_reg(CFG_SIZE_Z, 1);
    write_reg(CFG_THICKNESS, 1023);
    write_reg(CFG_SPARE_LO, 11'h7ff);
    push_load(8, 23040, 11520);
    push_eval(5, 700, 3);
    push_eval(1023, 0, 512);
    drain();
    write_reg(CFG_THICKNESS, 0);
    push_load(9, pick_angle(), pick_angle());
    push_eval(7, 7, 7);
    drain();

    // fill the whole store, then sum all of it and a saturating count
    write_reg(CFG_THICKNESS, 3);
    write_reg(CFG_SIZE_X, 64);
    write_reg(CFG_SIZE_Y, 32);
    write_reg(CFG_SIZE_Z, 16);
    no_gaps = 1'b1;
    for (int s = 0; s < NSLOTS; s++) push_load(s, pick_angle(), pick_angle());
    drain();
    write_reg(CFG_TILT_COUNT, 64);
    push_eval(0, 0, 0);
    push_eval($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    drain();
    write_reg(CFG_TILT_COUNT, 127);
    push_eval(1, 2, 3);
    push_eval($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
    drain();

    // random phases, mostly few tilts so the run stays short
    for (int ph = 0; ph < 32; ph++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      write_reg(CFG_SIZE_X, pick_extent());
      write_reg(CFG_SIZE_Y, pick_extent());
      write_reg(CFG_SIZE_Z, pick_extent());
      case ($urandom_range(0, 5))
        0: th = 0;
        1: th = 1023;
        2: th = $urandom_range(0, 1023);
        default: th = $urandom_range(1, 8);
      endcase
      write_reg(CFG_THICKNESS, th);
      write_reg(3'($urandom_range(CFG_SPARE_LO, 7)), $urandom_range(0, 2047));
      lim = loaded_prefix();
      if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, (lim < 12) ? lim : 12);
      else cnt = $urandom_range(0, (lim < 4) ? lim : 4);
      write_reg(CFG_TILT_COUNT, cnt);
      for (int i = 0; i < 48; i++) begin
        if ($urandom_range(0, 9) < 3)
          push_load($urandom_range(0, NSLOTS - 1), pick_angle(), pick_angle());
        else
          push_eval($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
      end
      drain();
    end

    if (mismatches == 0 && stray_results == 0 && weights_due.size() == 0)
      $display("tomo_weight_3d_sinc_sum_tb passed");
    else
      $display("tomo_weight_3d_sinc_sum_tb failed");
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #40000000;
    $display("tomo_weight_3d_sinc_sum_tb failed");
    $finish;
  end

endmodule
